// File: hdl/ofrp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ofrp_pkg
// Shared widths, codes and the result item type of the face record parser.
// ----------------------------------------------------------------------------
package ofrp_pkg;

	localparam int INDEX_BITS_DEF = 24;
	localparam int FIELD_W        = 24;
	localparam int CH_W           = 8;
	localparam int FAULT_W        = 2;
	localparam int TOTAL_W        = 8;
	localparam int INCR_W         = 3;
	localparam int PUSH_W         = 2;
	localparam int RES_DEPTH      = 4;

	localparam logic KIND_VERTEX  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [CH_W-1:0] CH_NEWLINE = 8'd10;

	typedef struct packed {
		logic               kind;
		logic [FIELD_W-1:0] pos_index;
		logic [FIELD_W-1:0] tex_index;
		logic [FIELD_W-1:0] nrm_index;
		logic [FAULT_W-1:0] fault;
		logic [TOTAL_W-1:0] vertex_total;
		logic [INCR_W-1:0]  index_increment;
		logic               last;
	} res_t;

endpackage
`default_nettype wire

// File: hdl/ofrp_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ofrp_parse
// Token state machine and index resolution; emits up to two result items
// for the byte held in the input register.
// ----------------------------------------------------------------------------
module ofrp_parse
	import ofrp_pkg::*;
#(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic [CH_W-1:0]    ch,
	input  wire logic [FIELD_W-1:0] pos_count,
	input  wire logic [FIELD_W-1:0] tex_count,
	input  wire logic [FIELD_W-1:0] nrm_count,
	output logic [PUSH_W-1:0]       push_n,
	output res_t                    res0,
	output res_t                    res1
);

	localparam int IB = INDEX_BITS;
	localparam int MW = IB + 1;
	localparam int PW = MW + 4;

	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_POS       = 3'd1;
	localparam logic [2:0] PH_TEX_EMPTY = 3'd2;
	localparam logic [2:0] PH_TEX       = 3'd3;
	localparam logic [2:0] PH_NRM_EMPTY = 3'd4;
	localparam logic [2:0] PH_NRM       = 3'd5;

	localparam logic [FAULT_W-1:0] FLT_OK    = 2'd0;
	localparam logic [FAULT_W-1:0] FLT_ZERO  = 2'd1;
	localparam logic [FAULT_W-1:0] FLT_RANGE = 2'd2;
	localparam logic [FAULT_W-1:0] FLT_BYTE  = 2'd3;

	localparam logic [INCR_W-1:0] INCR_TRI   = 3'd3;
	localparam logic [INCR_W-1:0] INCR_OTHER = 3'd6;
	localparam logic [TOTAL_W-1:0] TOTAL_TRI = 8'd3;

	localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
	localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CH_W-1:0] CH_CR    = 8'd13;
	localparam logic [CH_W-1:0] CH_VT    = 8'd11;
	localparam logic [CH_W-1:0] CH_FF    = 8'd12;
	localparam logic [CH_W-1:0] CH_ZERO  = 8'd48;
	localparam logic [CH_W-1:0] CH_NINE  = 8'd57;
	localparam logic [CH_W-1:0] CH_MINUS = 8'd45;
	localparam logic [CH_W-1:0] CH_PLUS  = 8'd43;
	localparam logic [CH_W-1:0] CH_SLASH = 8'd47;

	logic [2:0]         phase_q, phase_d;
	logic               neg_q, neg_d;
	logic [MW-1:0]      accum_q, accum_d;
	logic [MW:0]        held_pos_q, held_pos_d;
	logic [MW:0]        held_tex_q, held_tex_d;
	logic [TOTAL_W-1:0] fv_q, fv_d;
	logic [FAULT_W-1:0] tfault_q, tfault_d;

	function automatic logic [FAULT_W-1:0] fmax(input logic [FAULT_W-1:0] a,
		input logic [FAULT_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [IB+FAULT_W-1:0] resolve(input logic [MW:0] fld,
		input logic [IB-1:0] cnt, input logic is_pos);
		logic [MW-1:0]      mag;
		logic [MW-1:0]      cnt_x;
		logic [MW-1:0]      diff;
		logic [MW-1:0]      dec;
		logic [FAULT_W-1:0] f;
		logic [IB-1:0]      idx;
		mag   = fld[MW-1:0];
		cnt_x = {1'b0, cnt};
		diff  = cnt_x - mag;
		dec   = mag - 1'b1;
		f     = FLT_OK;
		idx   = '0;
		if (mag == '0) begin
			f = is_pos ? FLT_ZERO : FLT_OK;
		end else if (fld[MW]) begin
			if (mag > cnt_x) begin
				f = FLT_RANGE;
			end else begin
				idx = diff[IB-1:0];
			end
		end else begin
			idx = dec[IB-1:0];
		end
		return {f, idx};
	endfunction

	logic                  is_nl, is_ws, is_dig, is_sign, is_slash, tok_end;
	logic [MW:0]           pack, pp, tp, np;
	logic [IB+FAULT_W-1:0] rp, rt, rn;
	logic [FAULT_W-1:0]    vfault;
	logic [TOTAL_W-1:0]    fv_inc, sum_total;
	logic [CH_W-1:0]       dd;
	logic [PW-1:0]         prod, cap;
	res_t                  vtx, summ;

	always_comb begin
		is_nl    = (ch == CH_NEWLINE);
		is_ws    = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) ||
		           (ch == CH_VT) || (ch == CH_FF);
		is_dig   = (ch >= CH_ZERO) && (ch <= CH_NINE);
		is_sign  = (ch == CH_MINUS) || (ch == CH_PLUS);
		is_slash = (ch == CH_SLASH);
		tok_end  = (is_nl || is_ws) && (phase_q != PH_IDLE);
		pack     = {neg_q, accum_q};

		case (phase_q)
			PH_POS: begin
				pp = pack;
				tp = '0;
				np = '0;
			end
			PH_TEX_EMPTY, PH_TEX: begin
				pp = held_pos_q;
				tp = pack;
				np = '0;
			end
			default: begin
				pp = held_pos_q;
				tp = held_tex_q;
				np = pack;
			end
		endcase

		rp     = resolve(pp, IB'(pos_count), 1'b1);
		rt     = resolve(tp, IB'(tex_count), 1'b0);
		rn     = resolve(np, IB'(nrm_count), 1'b0);
		vfault = fmax(fmax(tfault_q, rp[IB+FAULT_W-1:IB]),
		              fmax(rt[IB+FAULT_W-1:IB], rn[IB+FAULT_W-1:IB]));
		fv_inc = (fv_q == '1) ? fv_q : fv_q + 1'b1;
		sum_total = tok_end ? fv_inc : fv_q;

		vtx.kind            = KIND_VERTEX;
		vtx.pos_index       = FIELD_W'(rp[IB-1:0]);
		vtx.tex_index       = FIELD_W'(rt[IB-1:0]);
		vtx.nrm_index       = FIELD_W'(rn[IB-1:0]);
		vtx.fault           = vfault;
		vtx.vertex_total    = fv_inc;
		vtx.index_increment = (fv_inc == TOTAL_TRI) ? INCR_TRI : INCR_OTHER;
		vtx.last            = is_ws;

		summ.kind            = KIND_SUMMARY;
		summ.pos_index       = '0;
		summ.tex_index       = '0;
		summ.nrm_index       = '0;
		summ.fault           = FLT_OK;
		summ.vertex_total    = sum_total;
		summ.index_increment = (sum_total == TOTAL_TRI) ? INCR_TRI : INCR_OTHER;
		summ.last            = 1'b1;

		res0 = tok_end ? vtx : summ;
		res1 = summ;

		if (!step) begin
			push_n = 2'd0;
		end else if (is_nl) begin
			push_n = tok_end ? 2'd2 : 2'd1;
		end else begin
			push_n = tok_end ? 2'd1 : 2'd0;
		end

		dd   = ch - CH_ZERO;
		cap  = PW'(1) << IB;
		prod = (PW'(accum_q) << 3) + (PW'(accum_q) << 1) + PW'(dd[3:0]);

		phase_d    = phase_q;
		neg_d      = neg_q;
		accum_d    = accum_q;
		held_pos_d = held_pos_q;
		held_tex_d = held_tex_q;
		fv_d       = fv_q;
		tfault_d   = tfault_q;

		if (is_nl || is_ws) begin
			if (tok_end) begin
				phase_d    = PH_IDLE;
				neg_d      = 1'b0;
				accum_d    = '0;
				held_pos_d = '0;
				held_tex_d = '0;
				tfault_d   = FLT_OK;
			end
			if (is_nl) begin
				fv_d = '0;
			end else if (tok_end) begin
				fv_d = fv_inc;
			end
		end else if (is_dig) begin
			if (prod > cap) begin
				accum_d  = cap[MW-1:0];
				tfault_d = fmax(tfault_q, FLT_RANGE);
			end else begin
				accum_d = prod[MW-1:0];
			end
			case (phase_q)
				PH_IDLE:      phase_d = PH_POS;
				PH_TEX_EMPTY: phase_d = PH_TEX;
				PH_NRM_EMPTY: phase_d = PH_NRM;
				default:      phase_d = phase_q;
			endcase
		end else if (is_sign) begin
			case (phase_q)
				PH_IDLE: begin
					neg_d   = (ch == CH_MINUS);
					phase_d = PH_POS;
				end
				PH_TEX_EMPTY: begin
					neg_d   = (ch == CH_MINUS);
					phase_d = PH_TEX;
				end
				PH_NRM_EMPTY: begin
					neg_d   = (ch == CH_MINUS);
					phase_d = PH_NRM;
				end
				default: tfault_d = fmax(tfault_q, FLT_BYTE);
			endcase
		end else if (is_slash) begin
			case (phase_q)
				PH_IDLE, PH_POS: begin
					held_pos_d = pack;
					accum_d    = '0;
					neg_d      = 1'b0;
					phase_d    = PH_TEX_EMPTY;
				end
				PH_TEX_EMPTY, PH_TEX: begin
					held_tex_d = pack;
					accum_d    = '0;
					neg_d      = 1'b0;
					phase_d    = PH_NRM_EMPTY;
				end
				default: tfault_d = fmax(tfault_q, FLT_BYTE);
			endcase
		end else begin
			tfault_d = fmax(tfault_q, FLT_BYTE);
			if (phase_q == PH_IDLE) begin
				phase_d = PH_POS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			neg_q      <= 1'b0;
			accum_q    <= '0;
			held_pos_q <= '0;
			held_tex_q <= '0;
			fv_q       <= '0;
			tfault_q   <= FLT_OK;
		end else if (step) begin
			phase_q    <= phase_d;
			neg_q      <= neg_d;
			accum_q    <= accum_d;
			held_pos_q <= held_pos_d;
			held_tex_q <= held_tex_d;
			fv_q       <= fv_d;
			tfault_q   <= tfault_d;
		end
	end

endmodule
`default_nettype wire

// File: hdl/ofrp_rfifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ofrp_rfifo
// Result queue: takes up to two items per cycle, hands out one.
// ----------------------------------------------------------------------------
module ofrp_rfifo
	import ofrp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [PUSH_W-1:0] push_n,
	input  wire res_t              d0,
	input  wire res_t              d1,
	input  wire logic              pop,
	output res_t                   head,
	output logic                   not_empty,
	output logic                   room2
);

	localparam int PTR_W = $clog2(RES_DEPTH);
	localparam int CNT_W = $clog2(RES_DEPTH + 1);

	res_t             mem [RES_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic             pop_ok;

	assign wr_nxt    = wr_ptr_q + 1'b1;
	assign not_empty = (cnt_q != '0);
	assign pop_ok    = pop && not_empty;
	assign room2     = (cnt_q <= CNT_W'(RES_DEPTH - 2));
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem[wr_ptr_q] <= d0;
		end
		if (push_n == 2'd2) begin
			mem[wr_nxt] <= d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(push_n) - CNT_W'(pop_ok);
		end
	end

endmodule
`default_nettype wire

// File: hdl/obj_face_record_parser_unit.sv
// An accepted byte is registered, then its items go to a four-entry result queue.
// Throughput: one byte per cycle while the queue has room; a newline that closes a
// token gives two items; the output side drains one item per cycle while res_ready.
// Input register stalls only when the queue has fewer than two free entries.
// Reset: arst_n clears the parser state, face vertex count and queue at once.
`default_nettype none
// ----------------------------------------------------------------------------
// obj_face_record_parser_unit
// Face record byte parser: resolves vertex index tokens and emits a face
// summary on newline.
// ----------------------------------------------------------------------------
module obj_face_record_parser_unit
	import ofrp_pkg::*;
#(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire logic [CH_W-1:0]    ch,
	input  wire logic [FIELD_W-1:0] pos_count,
	input  wire logic [FIELD_W-1:0] tex_count,
	input  wire logic [FIELD_W-1:0] nrm_count,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output logic                    kind,
	output logic [FIELD_W-1:0]      pos_index,
	output logic [FIELD_W-1:0]      tex_index,
	output logic [FIELD_W-1:0]      nrm_index,
	output logic [FAULT_W-1:0]      fault,
	output logic [TOTAL_W-1:0]      vertex_total,
	output logic [INCR_W-1:0]       index_increment,
	output logic                    last
);

	logic               valid_s1;
	logic [CH_W-1:0]    ch_s1;
	logic [FIELD_W-1:0] pos_count_s1, tex_count_s1, nrm_count_s1;
	logic               step, room2, not_empty;
	logic [PUSH_W-1:0]  push_n;
	res_t               res0, res1, head;

	assign step       = valid_s1 && room2;
	assign item_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			ch_s1        <= ch;
			pos_count_s1 <= pos_count;
			tex_count_s1 <= tex_count;
			nrm_count_s1 <= nrm_count;
		end
	end

	ofrp_parse #(
		.INDEX_BITS(INDEX_BITS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.ch        (ch_s1),
		.pos_count (pos_count_s1),
		.tex_count (tex_count_s1),
		.nrm_count (nrm_count_s1),
		.push_n    (push_n),
		.res0      (res0),
		.res1      (res1)
	);

	ofrp_rfifo u_rfifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.d0        (res0),
		.d1        (res1),
		.pop       (res_valid && res_ready),
		.head      (head),
		.not_empty (not_empty),
		.room2     (room2)
	);

	assign res_valid       = not_empty;
	assign kind            = head.kind;
	assign pos_index       = head.pos_index;
	assign tex_index       = head.tex_index;
	assign nrm_index       = head.nrm_index;
	assign fault           = head.fault;
	assign vertex_total    = head.vertex_total;
	assign index_increment = head.index_increment;
	assign last            = head.last;

`ifndef SYNTH
	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind == KIND_SUMMARY) |-> last && (pos_index == '0) && (fault == '0))
		else $error("summary item malformed");

	a_vertex_counted: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind == KIND_VERTEX) |-> (vertex_total != '0))
		else $error("vertex item with zero vertex total");

	a_pair_on_newline: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n == 2'd2) |-> step && (ch_s1 == CH_NEWLINE))
		else $error("two items pushed for a byte other than newline");

	a_no_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |-> (push_n == 2'd0))
		else $error("item pushed without a byte in the input register");
`endif

endmodule
`default_nettype wire
